// ----- rtl/pqs_pkg.sv -----
package pqs_pkg;

  localparam int NSLOT  = 16;
  localparam int SW     = 4;
  localparam int NPRIO  = 8;
  localparam int LW     = 3;
  localparam int QW     = 4;
  localparam int PID_W  = 16;
  localparam int CNT_W  = 5;
  localparam int TIME_W = 11;
  localparam int CMD_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [SW:0] SLOT_NONE = (SW+1)'(NSLOT);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_PRIO   = 2'd3;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_KILLED  = 2'd2;
  localparam logic [1:0] ST_FREE    = 2'd3;

  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_ERR   = 2'd1;
  localparam logic [1:0] RC_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPRIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AGING = 2'd3;

  localparam logic [CMD_W-1:0] C_NONE       = 5'd0;
  localparam logic [CMD_W-1:0] C_LOAD       = 5'd1;
  localparam logic [CMD_W-1:0] C_REM_DEC    = 5'd2;
  localparam logic [CMD_W-1:0] C_EXPIRE     = 5'd3;
  localparam logic [CMD_W-1:0] C_PUSH_CUR   = 5'd4;
  localparam logic [CMD_W-1:0] C_DISP_INIT  = 5'd5;
  localparam logic [CMD_W-1:0] C_DISP_STEP  = 5'd6;
  localparam logic [CMD_W-1:0] C_CODE_FULL  = 5'd7;
  localparam logic [CMD_W-1:0] C_CREATE     = 5'd8;
  localparam logic [CMD_W-1:0] C_CR_PUSH    = 5'd9;
  localparam logic [CMD_W-1:0] C_FIND_T     = 5'd10;
  localparam logic [CMD_W-1:0] C_CODE_ERR   = 5'd11;
  localparam logic [CMD_W-1:0] C_PRIO_SET   = 5'd12;
  localparam logic [CMD_W-1:0] C_SET_STATUS = 5'd13;
  localparam logic [CMD_W-1:0] C_FIND_P     = 5'd14;
  localparam logic [CMD_W-1:0] C_UNBLOCK_P  = 5'd15;
  localparam logic [CMD_W-1:0] C_KILL_FIN   = 5'd16;
  localparam logic [CMD_W-1:0] C_OUT_LOAD   = 5'd17;

  typedef struct packed {
    logic [1:0]       op;
    logic [PID_W-1:0] target_pid;
    logic [1:0]       status_req;
    logic [2:0]       prio_req;
    logic             foreground;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_code;
    logic [PID_W-1:0] new_pid;
    logic             running_valid;
    logic [PID_W-1:0] running_pid;
    logic             switched;
    logic [CNT_W-1:0] alive_count;
    logic [CNT_W-1:0] ready_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cur_valid;
    logic       rem_gt1;
    logic       ready_nz;
    logic       disp_done;
    logic       free_found;
    logic       found;
    logic       ss_invalid;
    logic       ss_kill;
    logic       ss_need_parent;
    logic       kill_disp;
    logic       out_busy;
  } dp_status_t;

endpackage

// ----- rtl/pqs_ctrl.sv -----
module pqs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pqs_pkg::dp_status_t         sts,
  output logic [pqs_pkg::CMD_W-1:0]   cmd
);
  import pqs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_TICK   = 4'd2;
  localparam logic [3:0] S_TPUSH  = 4'd3;
  localparam logic [3:0] S_DINIT  = 4'd4;
  localparam logic [3:0] S_DISP   = 4'd5;
  localparam logic [3:0] S_CREATE = 4'd6;
  localparam logic [3:0] S_CPUSH  = 4'd7;
  localparam logic [3:0] S_FIND   = 4'd8;
  localparam logic [3:0] S_CHK    = 4'd9;
  localparam logic [3:0] S_PFIND  = 4'd10;
  localparam logic [3:0] S_PUNB   = 4'd11;
  localparam logic [3:0] S_KFIN   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = C_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = C_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_TICK:   state_next = S_TICK;
          OP_CREATE: state_next = S_CREATE;
          default:   state_next = S_FIND;
        endcase
      end
      S_TICK: begin
        if (sts.cur_valid) begin
          if (sts.rem_gt1) begin
            cmd        = C_REM_DEC;
            state_next = S_DONE;
          end else begin
            cmd        = C_EXPIRE;
            state_next = S_TPUSH;
          end
        end else if (sts.ready_nz) begin
          state_next = S_DINIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TPUSH: begin
        cmd        = C_PUSH_CUR;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd        = C_DISP_INIT;
        state_next = S_DISP;
      end
      S_DISP: begin
        cmd = C_DISP_STEP;
        if (sts.disp_done) state_next = S_DONE;
      end
      S_CREATE: begin
        if (sts.free_found) begin
          cmd        = C_CREATE;
          state_next = S_CPUSH;
        end else begin
          cmd        = C_CODE_FULL;
          state_next = S_DONE;
        end
      end
      S_CPUSH: begin
        cmd        = C_CR_PUSH;
        state_next = S_DONE;
      end
      S_FIND: begin
        cmd        = C_FIND_T;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (!sts.found) begin
          cmd        = C_CODE_ERR;
          state_next = S_DONE;
        end else if (sts.op == OP_PRIO) begin
          cmd        = C_PRIO_SET;
          state_next = S_DONE;
        end else begin
          cmd = C_SET_STATUS;
          if (sts.ss_invalid || !sts.ss_kill) state_next = S_DONE;
          else if (sts.ss_need_parent)        state_next = S_PFIND;
          else                                state_next = S_KFIN;
        end
      end
      S_PFIND: begin
        cmd        = C_FIND_P;
        state_next = S_PUNB;
      end
      S_PUNB: begin
        cmd        = C_UNBLOCK_P;
        state_next = S_KFIN;
      end
      S_KFIN: begin
        cmd        = C_KILL_FIN;
        state_next = sts.kill_disp ? S_DINIT : S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd        = C_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/pqs_dpath.sv -----
module pqs_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pqs_pkg::CMD_W-1:0]         cmd,
  output pqs_pkg::dp_status_t               sts,
  input  pqs_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pqs_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  input  logic [pqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pqs_pkg::*;

  // Slot table.
  logic [1:0]       st   [NSLOT];
  logic [PID_W-1:0] pid  [NSLOT];
  logic [PID_W-1:0] par  [NSLOT];
  logic [LW-1:0]    pri  [NSLOT];
  logic             fgd  [NSLOT];
  logic [15:0]      age  [NSLOT];
  logic [SW:0]      nxt  [NSLOT];
  logic             qd   [NSLOT];
  // Queue heads and tails, active and expired arrays.
  logic [SW:0]      qhead [2*NPRIO];
  logic [SW:0]      qtail [2*NPRIO];

  logic              active;
  logic [LW-1:0]     scan;
  logic              pass;
  logic [SW:0]       cur;
  logic [TIME_W-1:0] rem;
  logic [CNT_W-1:0]  alive, ready;
  logic [PID_W-1:0]  pidc;

  logic [7:0]        qslope, qbase;
  logic [LW-1:0]     bprio;
  logic              aging_en;

  in_item_t          item;
  logic [SW:0]       prev_cur;
  logic [1:0]        code;
  logic [PID_W-1:0]  npid;
  logic [SW-1:0]     sidx, pidx;
  logic              found;
  logic [1:0]        last_st;

  logic              cur_valid;
  logic [SW-1:0]     ci;
  logic [QW-1:0]     q_act;
  logic [SW:0]       h;
  logic              h_none;
  logic [TIME_W-1:0] quantum;
  logic              free_found;
  logic [SW-1:0]     free_idx;
  logic [PID_W-1:0]  key;
  logic              m_found;
  logic [SW-1:0]     m_idx;
  logic              drop_hit;
  logic              pop_en, push_en;
  logic [SW-1:0]     ps;
  logic [QW-1:0]     qp;
  logic [SW:0]       pt;
  logic [SW:0]       pn;
  logic              ss_invalid;
  logic              dec_r;
  logic [CNT_W-1:0]  ready_after;
  logic              blk_cur;

  assign cur_valid = !cur[SW];
  assign ci        = cur[SW-1:0];
  assign q_act     = {active, scan};
  assign h         = qhead[q_act];
  assign h_none    = h[SW];
  assign pn        = nxt[h[SW-1:0]];
  assign quantum   = TIME_W'(qslope) * TIME_W'(scan) + TIME_W'(qbase);
  assign drop_hit  = cur_valid && (h == cur);

  // Lowest slot that is free or killed.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (st[i] == ST_FREE || st[i] == ST_KILLED) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign key = (cmd == C_FIND_P) ? par[sidx] : item.target_pid;

  always_comb begin
    m_found = 1'b0;
    m_idx   = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (st[i] != ST_FREE && pid[i] == key) begin
        m_found = 1'b1;
        m_idx   = SW'(i);
      end
    end
  end

  assign ss_invalid = (item.status_req == ST_FREE) || (st[sidx] == item.status_req) ||
                      (st[sidx] == ST_KILLED);
  assign dec_r       = (last_st == ST_READY) && (ready != '0);
  assign ready_after = ready - CNT_W'(dec_r);
  assign blk_cur     = cur_valid && fgd[sidx] && (st[ci] == ST_READY);

  always_comb begin
    pop_en  = 1'b0;
    push_en = 1'b0;
    ps      = sidx;
    case (cmd)
      C_EXPIRE:    pop_en = drop_hit;
      C_KILL_FIN:  pop_en = drop_hit && (ci == sidx);
      C_DISP_STEP: pop_en = !h_none && (st[h[SW-1:0]] != ST_READY);
      C_PUSH_CUR: begin
        ps      = ci;
        push_en = (st[ci] != ST_BLOCKED);
      end
      C_CR_PUSH:   push_en = 1'b1;
      C_SET_STATUS: begin
        push_en = !ss_invalid && (st[sidx] == ST_BLOCKED) && (item.status_req == ST_READY);
      end
      C_UNBLOCK_P: begin
        ps      = pidx;
        push_en = found && (st[pidx] == ST_BLOCKED);
      end
      default: begin
        pop_en  = 1'b0;
        push_en = 1'b0;
      end
    endcase
  end

  assign qp = {~active, pri[ps]};
  assign pt = qtail[qp];

  always_comb begin
    sts.op             = item.op;
    sts.cur_valid      = cur_valid;
    sts.rem_gt1        = rem > TIME_W'(1);
    sts.ready_nz       = ready != '0;
    sts.disp_done      = (!h_none && st[h[SW-1:0]] == ST_READY) ||
                         (h_none && scan == LW'(NPRIO - 1) && (ready == '0 || pass));
    sts.free_found     = free_found;
    sts.found          = found;
    sts.ss_invalid     = ss_invalid;
    sts.ss_kill        = item.status_req == ST_KILLED;
    sts.ss_need_parent = fgd[sidx] && (par[sidx] != '0);
    sts.kill_disp      = (cur == {1'b0, sidx}) && (ready_after != '0);
    sts.out_busy       = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        st[i] <= ST_FREE;
        qd[i] <= 1'b0;
      end
      for (int i = 0; i < 2 * NPRIO; i++) begin
        qhead[i] <= SLOT_NONE;
        qtail[i] <= SLOT_NONE;
      end
      active    <= 1'b0;
      scan      <= '0;
      pass      <= 1'b0;
      cur       <= SLOT_NONE;
      rem       <= '0;
      alive     <= '0;
      ready     <= '0;
      pidc      <= '0;
      qslope    <= 8'd1;
      qbase     <= 8'd1;
      bprio     <= 3'd4;
      aging_en  <= 1'b0;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SLOPE: qslope   <= cfg_data;
          REG_BASE:  qbase    <= cfg_data;
          REG_BPRIO: bprio    <= cfg_data[LW-1:0];
          REG_AGING: aging_en <= cfg_data[0];
          default:   qslope   <= qslope;
        endcase
      end

      if (out_valid && out_ready && cmd != C_OUT_LOAD) out_valid <= 1'b0;

      // Unlink the head of the active queue that the scan points at.
      if (pop_en) begin
        if (qtail[q_act] == h || pn[SW]) begin
          qhead[q_act] <= SLOT_NONE;
          qtail[q_act] <= SLOT_NONE;
        end else begin
          qhead[q_act] <= pn;
        end
        qd[h[SW-1:0]] <= 1'b0;
      end

      // Append to the expired array; a slot already queued keeps its place.
      if (push_en && !qd[ps]) begin
        nxt[ps] <= SLOT_NONE;
        if (!pt[SW]) nxt[pt[SW-1:0]] <= {1'b0, ps};
        else         qhead[qp] <= {1'b0, ps};
        qtail[qp] <= {1'b0, ps};
        qd[ps]    <= 1'b1;
      end

      case (cmd)
        C_LOAD: begin
          item     <= in_item;
          prev_cur <= cur;
          code     <= RC_OK;
          npid     <= '0;
        end
        C_REM_DEC: rem <= rem - TIME_W'(1);
        C_EXPIRE: begin
          rem     <= '0;
          age[ci] <= age[ci] + 16'd1;
          if (aging_en && pri[ci] != LW'(NPRIO - 1)) pri[ci] <= pri[ci] + LW'(1);
        end
        C_PUSH_CUR: cur <= SLOT_NONE;
        C_DISP_INIT: pass <= 1'b0;
        C_DISP_STEP: begin
          if (h_none) begin
            if (scan != LW'(NPRIO - 1)) begin
              scan <= scan + LW'(1);
            end else begin
              active <= ~active;
              scan   <= '0;
              cur    <= SLOT_NONE;
              pass   <= 1'b1;
            end
          end else if (st[h[SW-1:0]] == ST_READY) begin
            cur <= h;
            rem <= quantum;
          end
        end
        C_CODE_FULL: code <= RC_FULL;
        C_CODE_ERR:  code <= RC_ERR;
        C_CREATE: begin
          sidx           <= free_idx;
          pid[free_idx]  <= pidc + PID_W'(1);
          par[free_idx]  <= cur_valid ? pid[ci] : '0;
          fgd[free_idx]  <= cur_valid ? (fgd[ci] & item.foreground) : 1'b1;
          pri[free_idx]  <= bprio;
          st[free_idx]   <= ST_READY;
          age[free_idx]  <= '0;
          alive          <= alive + CNT_W'(1);
          ready          <= ready + CNT_W'(1);
          pidc           <= pidc + PID_W'(1);
          npid           <= pidc + PID_W'(1);
        end
        C_CR_PUSH: begin
          // A foreground child blocks its running parent.
          if (blk_cur) begin
            st[ci] <= ST_BLOCKED;
            if (ready != '0) ready <= ready - CNT_W'(1);
            rem    <= TIME_W'(1);
          end
        end
        C_FIND_T: begin
          sidx  <= m_idx;
          found <= m_found;
        end
        C_FIND_P: begin
          pidx  <= m_idx;
          found <= m_found;
        end
        C_PRIO_SET: begin
          if (st[sidx] == ST_KILLED) code <= RC_ERR;
          else                       pri[sidx] <= item.prio_req;
        end
        C_SET_STATUS: begin
          last_st <= st[sidx];
          if (ss_invalid) begin
            code <= RC_ERR;
          end else begin
            st[sidx] <= item.status_req;
            if (st[sidx] == ST_BLOCKED && item.status_req == ST_READY) begin
              ready <= ready + CNT_W'(1);
            end else if (st[sidx] == ST_READY && item.status_req == ST_BLOCKED) begin
              if (ready != '0) ready <= ready - CNT_W'(1);
              if (cur == {1'b0, sidx}) rem <= TIME_W'(1);
            end
          end
        end
        C_UNBLOCK_P: begin
          if (found && st[pidx] == ST_BLOCKED) begin
            st[pidx] <= ST_READY;
            ready    <= ready + CNT_W'(1);
          end
        end
        C_KILL_FIN: begin
          if (alive != '0) alive <= alive - CNT_W'(1);
          ready <= ready_after;
          if (cur == {1'b0, sidx}) cur <= SLOT_NONE;
        end
        C_OUT_LOAD: begin
          out_valid              <= 1'b1;
          out_item.result_code   <= code;
          out_item.new_pid       <= npid;
          out_item.running_valid <= cur_valid;
          out_item.running_pid   <= cur_valid ? pid[ci] : '0;
          out_item.switched      <= cur != prev_cur;
          out_item.alive_count   <= alive;
          out_item.ready_count   <= ready;
        end
        default: rem <= rem;
      endcase
    end
  end

endmodule

// ----- rtl/priority_quantum_scheduler_unit.sv -----
// One event at a time: a new event is taken only in the idle state. A tick that dispatches
// may walk both queue arrays, one level or one dropped head per cycle.
// The dispatch scan and a held result beat both delay the return to idle.
// The next event is taken while the previous result beat still waits at the output.
// Synchronous reset: all slots free, all queues empty, idle, registers at defaults.
module priority_quantum_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pqs_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pqs_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pqs_pkg::*;

  logic [CMD_W-1:0] cmd;
  dp_status_t       sts;

  assign cfg_ready = 1'b1;

  pqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pqs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- dv/priority_quantum_scheduler_unit_test.sv -----
`timescale 1ns / 1ps

module priority_quantum_scheduler_unit_test;
  import pqs_pkg::*;

  localparam int NQ = 2 * NPRIO;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  priority_quantum_scheduler_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scheduler shadow state.
  logic [1:0]       slot_state [NSLOT];
  logic [PID_W-1:0] slot_id    [NSLOT];
  logic [PID_W-1:0] slot_owner [NSLOT];
  logic [LW-1:0]    slot_level [NSLOT];
  bit               slot_fg    [NSLOT];
  bit [15:0]        slot_age   [NSLOT];
  int               slot_link  [NSLOT];
  bit               slot_inq   [NSLOT];
  int               qhead [NQ];
  int               qtail [NQ];
  int               cur_array, cur_level, run_slot, ticks_left;
  int               n_alive, n_ready;
  logic [PID_W-1:0] last_pid;
  int               q_slope, q_base;
  logic [LW-1:0]    q_bprio;
  bit               q_aging;

  out_item_t expected_results[$];
  int        failures;
  int        events_sent, results_seen, reg_writes;
  int        gap_pct, stall_pct;

  function automatic void sched_clear();
    for (int i = 0; i < NSLOT; i++) begin
      slot_state[i] = ST_FREE;
      slot_id[i] = '0;
      slot_owner[i] = '0;
      slot_level[i] = '0;
      slot_fg[i] = 1'b0;
      slot_age[i] = '0;
      slot_link[i] = 0;
      slot_inq[i] = 1'b0;
    end
    for (int q = 0; q < NQ; q++) begin
      qhead[q] = NSLOT;
      qtail[q] = NSLOT;
    end
    cur_array = 0;
    cur_level = 0;
    run_slot = NSLOT;
    ticks_left = 0;
    n_alive = 0;
    n_ready = 0;
    last_pid = '0;
    q_slope = 1;
    q_base = 1;
    q_bprio = 3'd4;
    q_aging = 1'b0;
  endfunction

  function automatic void queue_pop(int q);
    int h;
    h = qhead[q];
    if (h >= NSLOT) return;
    if (qtail[q] == h) begin
      qhead[q] = NSLOT;
      qtail[q] = NSLOT;
    end else begin
      qhead[q] = (slot_link[h] < NSLOT) ? slot_link[h] : NSLOT;
      if (qhead[q] == NSLOT) qtail[q] = NSLOT;
    end
    slot_inq[h] = 1'b0;
  endfunction

  // New, unblocked and expired tasks always go to the expired array.
  function automatic void queue_push(int s);
    int q;
    if (slot_inq[s]) return;
    q = (1 - cur_array) * NPRIO + int'(slot_level[s]);
    slot_link[s] = NSLOT;
    if (qtail[q] < NSLOT) slot_link[qtail[q]] = s;
    else qhead[q] = s;
    qtail[q] = s;
    slot_inq[s] = 1'b1;
  endfunction

  function automatic void pick_next_task();
    int q;
    int h;
    for (int pass = 0; pass < 2; pass++) begin
      while (cur_level < NPRIO) begin
        q = cur_array * NPRIO + cur_level;
        h = qhead[q];
        if (h >= NSLOT) begin
          cur_level++;
          continue;
        end
        if (slot_state[h] == ST_READY) begin
          run_slot = h;
          ticks_left = q_slope * cur_level + q_base;
          return;
        end
        queue_pop(q);
      end
      cur_array ^= 1;
      cur_level = 0;
      run_slot = NSLOT;
      if (n_ready == 0) return;
    end
  endfunction

  function automatic void unlink_running();
    int q;
    if (run_slot >= NSLOT || cur_level >= NPRIO) return;
    q = cur_array * NPRIO + cur_level;
    if (qhead[q] == run_slot) queue_pop(q);
  endfunction

  function automatic int slot_of_pid(logic [PID_W-1:0] pid);
    for (int i = 0; i < NSLOT; i++)
      if (slot_state[i] != ST_FREE && slot_id[i] == pid) return i;
    return -1;
  endfunction

  function automatic logic [1:0] change_status(int i, logic [1:0] ns);
    logic [1:0] prev;
    int p;
    prev = slot_state[i];
    if (ns == ST_FREE || prev == ns || prev == ST_KILLED) return RC_ERR;
    slot_state[i] = ns;
    if (prev == ST_BLOCKED && ns == ST_READY) begin
      queue_push(i);
      n_ready++;
    end else if (prev == ST_READY && ns == ST_BLOCKED) begin
      if (n_ready > 0) n_ready--;
      if (run_slot == i) ticks_left = 1;
    end else if (ns == ST_KILLED) begin
      if (slot_fg[i] && slot_owner[i] != 0) begin
        p = slot_of_pid(slot_owner[i]);
        if (p >= 0) void'(change_status(p, ST_READY));
      end
      if (n_alive > 0) n_alive--;
      if (prev == ST_READY && n_ready > 0) n_ready--;
      if (run_slot == i) begin
        unlink_running();
        run_slot = NSLOT;
        if (n_ready > 0) pick_next_task();
      end
    end
    return RC_OK;
  endfunction

  function automatic void sched_tick();
    int c;
    c = run_slot;
    if (c < NSLOT) begin
      if (ticks_left > 1) begin
        ticks_left--;
        return;
      end
      ticks_left = 0;
      slot_age[c] = slot_age[c] + 16'd1;
      unlink_running();
      if (q_aging && slot_level[c] != 3'd7) slot_level[c] = slot_level[c] + 3'd1;
      if (slot_state[c] != ST_BLOCKED) queue_push(c);
      run_slot = NSLOT;
      pick_next_task();
    end else if (n_ready > 0) begin
      pick_next_task();
    end
  endfunction

  function automatic logic [1:0] sched_create(bit fg, output logic [PID_W-1:0] pid);
    int i;
    int c;
    c = run_slot;
    pid = '0;
    for (i = 0; i < NSLOT; i++)
      if (slot_state[i] == ST_FREE || slot_state[i] == ST_KILLED) break;
    if (i >= NSLOT) return RC_FULL;
    pid = last_pid + 1'b1;
    slot_id[i] = pid;
    slot_owner[i] = (c < NSLOT) ? slot_id[c] : '0;
    slot_fg[i] = (c >= NSLOT) ? 1'b1 : (slot_fg[c] ? fg : 1'b0);
    slot_level[i] = q_bprio;
    slot_state[i] = ST_READY;
    slot_age[i] = '0;
    queue_push(i);
    n_alive++;
    n_ready++;
    last_pid = pid;
    if (c < NSLOT && slot_fg[i]) void'(change_status(c, ST_BLOCKED));
    return RC_OK;
  endfunction

  function automatic out_item_t predict_event(in_item_t ev);
    out_item_t r;
    int prev_slot;
    int s;
    logic [PID_W-1:0] pid;
    prev_slot = run_slot;
    r = '0;
    case (ev.op)
      OP_TICK: sched_tick();
      OP_CREATE: begin
        r.result_code = sched_create(ev.foreground, pid);
        r.new_pid = pid;
      end
      OP_STATUS: begin
        s = slot_of_pid(ev.target_pid);
        r.result_code = (s < 0) ? RC_ERR : change_status(s, ev.status_req);
      end
      default: begin
        s = slot_of_pid(ev.target_pid);
        if (s < 0 || slot_state[s] == ST_KILLED) r.result_code = RC_ERR;
        else slot_level[s] = ev.prio_req;
      end
    endcase
    r.running_valid = (run_slot < NSLOT);
    r.running_pid = (run_slot < NSLOT) ? slot_id[run_slot] : '0;
    r.switched = (run_slot != prev_slot);
    r.alive_count = CNT_W'(n_alive);
    r.ready_count = CNT_W'(n_ready);
    return r;
  endfunction

  task automatic send_event(in_item_t ev);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_event(ev));
    events_sent++;
  endtask

  task automatic send_op(logic [1:0] op, logic [PID_W-1:0] pid, logic [1:0] st,
                         logic [2:0] pr, bit fg);
    in_item_t ev;
    ev.op = op;
    ev.target_pid = pid;
    ev.status_req = st;
    ev.prio_req = pr;
    ev.foreground = fg;
    send_event(ev);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // All expected beats have been seen and the unit is back in idle; wait before going on.
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SLOPE: q_slope = int'(val);
      REG_BASE:  q_base = int'(val);
      REG_BPRIO: q_bprio = val[2:0];
      default:   q_aging = val[0];
    endcase
    reg_writes++;
  endtask

  task automatic write_all_regs(int slope, int base, int bprio, bit aging);
    drain();
    write_reg(REG_SLOPE, CFG_DATA_W'(slope));
    write_reg(REG_BASE, CFG_DATA_W'(base));
    write_reg(REG_BPRIO, CFG_DATA_W'(bprio));
    write_reg(REG_AGING, CFG_DATA_W'(aging));
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    logic [PID_W-1:0] ids[NSLOT];
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (slot_state[i] != ST_FREE) begin
        ids[n] = slot_id[i];
        n++;
      end
    if (n == 0 || $urandom_range(9) == 0) return PID_W'($urandom);
    return ids[$urandom_range(n - 1)];
  endfunction

  // Ticks are the largest share, with enough creates to fill the table and enough kills to free it.
  task automatic send_random_event(int create_pct);
    int r;
    logic [1:0] st;
    r = $urandom_range(99);
    st = ($urandom_range(19) == 0) ? ST_FREE : 2'($urandom_range(2));
    if (r < create_pct)
      send_op(OP_CREATE, PID_W'($urandom), 2'($urandom), 3'($urandom), 1'($urandom_range(1)));
    else if (r < 50)
      send_op(OP_STATUS, pick_pid(), st, 3'($urandom), 1'($urandom_range(1)));
    else if (r < 60)
      send_op(OP_PRIO, pick_pid(), 2'($urandom), 3'($urandom), 1'($urandom_range(1)));
    else
      send_op(OP_TICK, PID_W'($urandom), 2'($urandom), 3'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic test_directed();
    send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_CREATE, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
    // Foreground child blocks its running parent, which then expires unqueued.
    send_op(OP_CREATE, '1, ST_KILLED, 3'd7, 1'b1);
    send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd2, ST_KILLED, 3'd0, 1'b0);
    send_op(OP_STATUS, '1, ST_READY, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd1, ST_FREE, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd1, ST_READY, 3'd0, 1'b0);
    send_op(OP_PRIO, 16'd1, ST_READY, 3'd7, 1'b0);
    send_op(OP_PRIO, 16'd2, ST_READY, 3'd0, 1'b0);
    send_op(OP_PRIO, '0, ST_READY, 3'd3, 1'b0);
    send_op(OP_STATUS, 16'd1, ST_BLOCKED, 3'd0, 1'b0);
    send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd1, ST_READY, 3'd0, 1'b0);
    send_op(OP_CREATE, '0, ST_READY, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd3, ST_BLOCKED, 3'd0, 1'b0);
    send_op(OP_STATUS, 16'd3, ST_KILLED, 3'd0, 1'b0);
    // The killed slot is reused while still queued.
    send_op(OP_CREATE, '0, ST_READY, 3'd0, 1'b1);
    for (int i = 0; i < 4; i++) send_op(OP_TICK, '0, ST_READY, 3'd0, 1'b0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 2; i++)
      send_op(OP_CREATE, '0, ST_READY, 3'd0, 1'($urandom_range(1)));
    for (int i = 0; i < 20; i++) send_random_event(5);
  endtask

  task automatic test_random_phase(int n, int gap, int stall, int create_pct);
    gap_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_random_event(create_pct);
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
      end else begin
        w = expected_results.pop_front();
        if (out_item.result_code !== w.result_code) begin
          $error("result_code expected %0d actual %0d", w.result_code, out_item.result_code);
          failures++;
        end
        if (out_item.new_pid !== w.new_pid) begin
          $error("new_pid expected %0d actual %0d", w.new_pid, out_item.new_pid);
          failures++;
        end
        if (out_item.running_valid !== w.running_valid) begin
          $error("running_valid expected %0d actual %0d", w.running_valid,
                 out_item.running_valid);
          failures++;
        end
        if (out_item.running_pid !== w.running_pid) begin
          $error("running_pid expected %0d actual %0d", w.running_pid, out_item.running_pid);
          failures++;
        end
        if (out_item.switched !== w.switched) begin
          $error("switched expected %0d actual %0d", w.switched, out_item.switched);
          failures++;
        end
        if (out_item.alive_count !== w.alive_count) begin
          $error("alive_count expected %0d actual %0d", w.alive_count, out_item.alive_count);
          failures++;
        end
        if (out_item.ready_count !== w.ready_count) begin
          $error("ready_count expected %0d actual %0d", w.ready_count, out_item.ready_count);
          failures++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("priority_quantum_scheduler_unit: mismatch");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    events_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    gap_pct = 0;
    stall_pct = 0;
    sched_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_phase(100, 0, 0, 25);
    write_all_regs(0, 255, 7, 1'b1);
    test_random_phase(100, 49, 0, 20);
    write_all_regs(255, 1, 0, 1'b0);
    test_random_phase(100, 0, 49, 25);
    // Base of zero: a task at level zero ends its quantum on the next tick.
    write_all_regs(0, 0, 0, 1'b1);
    test_random_phase(100, 13, 13, 20);
    write_all_regs($urandom_range(255), $urandom_range(255, 1), $urandom_range(7),
                   1'($urandom_range(1)));
    test_random_phase(90, 0, 0, 30);

    drain();
    $display("Sent %0d events, checked %0d result beats, made %0d register writes,",
             events_sent, results_seen, reg_writes);
    $display("covering fill, kill, block, aging and four idling patterns.");
    if (failures == 0) begin
      $display("priority_quantum_scheduler_unit: match");
    end else begin
      $display("priority_quantum_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
